// File: src/mbes3d_pkg.sv
// ----------------------------------------------------------------------------
// mbes3d_pkg
// Shared command and status types for the staircase front update block.
// ----------------------------------------------------------------------------
package mbes3d_pkg;

  // controller to datapath commands, at most one set per cycle
  typedef struct packed {
    logic load;     // capture item, form offsets, clear fronts on new anchor
    logic eval;     // search front, latch position, removal count and verdict
    logic remove;   // drop one dominated entry at the latched position
    logic insert;   // insert candidate at the latched position
    logic emit;     // move verdict into the output register
  } cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic eq_z;      // candidate z equals anchor z
    logic pred_dom;  // predecessor strictly dominates the candidate
    logic rem_zero;  // no dominated entries left to remove
    logic ins;       // key not yet stored, insert wanted
  } status_t;

endpackage

// File: src/mbes3d_ctrl.sv
// ----------------------------------------------------------------------------
// mbes3d_ctrl
// Sequencer for one item: evaluate, remove dominated entries, insert, emit.
// ----------------------------------------------------------------------------
module mbes3d_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  input  mbes3d_pkg::status_t sts,
  output mbes3d_pkg::cmd_t    cmd
);
  import mbes3d_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EVAL,
    S_REMOVE,
    S_INSERT,
    S_DONE
  } state_t;

  state_t state;
  logic   out_free;

  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;

  // command decode
  always_comb begin
    cmd = '0;
    case (state)
      S_IDLE:   cmd.load   = in_valid;
      S_EVAL:   cmd.eval   = 1'b1;
      S_REMOVE: cmd.remove = !sts.rem_zero;
      S_INSERT: cmd.insert = 1'b1;
      S_DONE:   cmd.emit   = out_free;
      default:  cmd = '0;
    endcase
  end

  // state and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      // result register valid: set on emit, cleared on transfer out
      if (state == S_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_EVAL;
          end
        end
        S_EVAL: begin
          if (sts.eq_z || sts.pred_dom) begin
            state <= S_DONE;
          end else begin
            state <= S_REMOVE;
          end
        end
        S_REMOVE: begin
          if (sts.rem_zero) begin
            state <= sts.ins ? S_INSERT : S_DONE;
          end
        end
        S_INSERT: state <= S_DONE;
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// File: src/mbes3d_dp.sv
// ----------------------------------------------------------------------------
// mbes3d_dp
// Offset forming, four staircase fronts held in cells, parallel compare,
// single-step removal and insertion shifts, and the result register.
// ----------------------------------------------------------------------------
module mbes3d_dp #(
  parameter int FRONT_DEPTH = 64,
  parameter int COORD_BITS  = 24
) (
  input  logic                         clk,
  input  logic                         rst,
  input  mbes3d_pkg::cmd_t             cmd,
  output mbes3d_pkg::status_t          sts,
  input  logic                         new_anchor,
  input  logic signed [COORD_BITS-1:0] anchor_y,
  input  logic signed [COORD_BITS-1:0] anchor_z,
  input  logic signed [COORD_BITS-1:0] cand_y,
  input  logic signed [COORD_BITS-1:0] cand_z,
  output logic                         is_edge,
  output logic                         front_overflow
);
  import mbes3d_pkg::*;

  localparam int OW    = COORD_BITS + 1;
  localparam int CNT_W = $clog2(FRONT_DEPTH + 1);
  localparam int IDX_W = (FRONT_DEPTH > 1) ? $clog2(FRONT_DEPTH) : 1;

  // front cells and counts
  logic [OW-1:0]    ey [4][FRONT_DEPTH];
  logic [OW-1:0]    ez [4][FRONT_DEPTH];
  logic [CNT_W-1:0] cnt [4];

  // working item
  logic [1:0]       qd;
  logic [OW-1:0]    dy, dz;
  logic             eq_z;
  logic [CNT_W-1:0] pos, rem;
  logic             ins, edge_r, ovf_r;

  // offsets from the anchor
  logic signed [OW-1:0] ydiff, zdiff;
  logic                 left, above;
  assign ydiff = OW'(cand_y) - OW'(anchor_y);
  assign zdiff = OW'(cand_z) - OW'(anchor_z);
  assign left  = ydiff[OW-1];
  assign above = !zdiff[OW-1] && (zdiff != '0);

  // parallel compare over the selected front
  logic [CNT_W-1:0] n, pos_c, end_c;
  logic [FRONT_DEPTH-1:0] le, dom;
  logic [IDX_W-1:0] pidx;
  logic [OW-1:0]    py, pz;
  logic             pred_dom, exists;

  always_comb begin
    n = cnt[qd];
    for (int i = 0; i < FRONT_DEPTH; i++) begin
      le[i]  = (CNT_W'(i) < n) && (ey[qd][i] <= dy);
    end
    pos_c = CNT_W'(FRONT_DEPTH);
    for (int i = FRONT_DEPTH - 1; i >= 0; i--) begin
      if (!le[i]) pos_c = CNT_W'(i);
    end
    for (int i = 0; i < FRONT_DEPTH; i++) begin
      dom[i] = (CNT_W'(i) < n) && (CNT_W'(i) >= pos_c) &&
               (dy < ey[qd][i]) && (dz < ez[qd][i]);
    end
    end_c = CNT_W'(FRONT_DEPTH);
    for (int i = FRONT_DEPTH - 1; i >= 0; i--) begin
      if (!dom[i] && (CNT_W'(i) >= pos_c)) end_c = CNT_W'(i);
    end
    pidx     = IDX_W'(pos_c - CNT_W'(1));
    py       = ey[qd][pidx];
    pz       = ez[qd][pidx];
    pred_dom = (pos_c != '0) && (py < dy) && (pz < dz);
    exists   = (pos_c != '0) && (py == dy);
  end

  assign sts.eq_z     = eq_z;
  assign sts.pred_dom = pred_dom;
  assign sts.rem_zero = (rem == '0);
  assign sts.ins      = ins;

  // counts
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int q = 0; q < 4; q++) cnt[q] <= '0;
    end else if (cmd.load && new_anchor) begin
      for (int q = 0; q < 4; q++) cnt[q] <= '0;
    end else if (cmd.remove) begin
      cnt[qd] <= cnt[qd] - CNT_W'(1);
    end else if (cmd.insert && (cnt[qd] != CNT_W'(FRONT_DEPTH))) begin
      cnt[qd] <= cnt[qd] + CNT_W'(1);
    end
  end

  // item, search results and verdict
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      qd    <= {!above, !left};
      dy    <= left ? OW'(-ydiff) : OW'(ydiff);
      dz    <= zdiff[OW-1] ? OW'(-zdiff) : OW'(zdiff);
      eq_z  <= (zdiff == '0);
    end
    if (cmd.eval) begin
      pos    <= pos_c;
      rem    <= end_c - pos_c;
      ins    <= !exists;
      edge_r <= eq_z || !pred_dom;
      ovf_r  <= 1'b0;
    end
    if (cmd.remove) begin
      rem <= rem - CNT_W'(1);
    end
    if (cmd.insert && (cnt[qd] == CNT_W'(FRONT_DEPTH))) begin
      ovf_r <= 1'b1;
    end
    if (cmd.emit) begin
      is_edge        <= edge_r;
      front_overflow <= ovf_r;
    end
  end

  // cell shifts: left by one on removal, right by one on insertion
  always_ff @(posedge clk) begin
    if (cmd.remove) begin
      for (int i = 0; i < FRONT_DEPTH - 1; i++) begin
        if (CNT_W'(i) >= pos) begin
          ey[qd][i] <= ey[qd][i+1];
          ez[qd][i] <= ez[qd][i+1];
        end
      end
    end else if (cmd.insert && (cnt[qd] != CNT_W'(FRONT_DEPTH))) begin
      for (int i = 1; i < FRONT_DEPTH; i++) begin
        if (CNT_W'(i) > pos) begin
          ey[qd][i] <= ey[qd][i-1];
          ez[qd][i] <= ez[qd][i-1];
        end
      end
      ey[qd][pos[IDX_W-1:0]] <= dy;
      ez[qd][pos[IDX_W-1:0]] <= dz;
    end
  end

endmodule

// File: src/minibox_edge_staircase_3d_top.sv
// ----------------------------------------------------------------------------
// minibox_edge_staircase_3d_top
// Pareto staircase update for 3-D minibox edge detection, one verdict per item.
// ----------------------------------------------------------------------------
// Each item is evaluated; then the stored entries it dominates are removed
// one by one and, if its key is not yet stored, the candidate is inserted
// before the result is emitted. An equal-z or dominated candidate goes
// straight to the result. All front entries are compared in parallel; each
// removal shifts the staircase by one cell per cycle, and an insertion is
// one more shift. One item is in work at a time; a finished result waits in
// the output register while the next item is taken.
module minibox_edge_staircase_3d_top #(
  parameter int FRONT_DEPTH = 64,
  parameter int COORD_BITS  = 24
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         new_anchor,
  input  logic signed [COORD_BITS-1:0] anchor_y,
  input  logic signed [COORD_BITS-1:0] anchor_z,
  input  logic signed [COORD_BITS-1:0] cand_y,
  input  logic signed [COORD_BITS-1:0] cand_z,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic                         is_edge,
  output logic                         front_overflow
);
  import mbes3d_pkg::*;

  cmd_t    cmd;
  status_t sts;

  // sequencer
  mbes3d_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  // fronts and compare datapath
  mbes3d_dp #(
    .FRONT_DEPTH (FRONT_DEPTH),
    .COORD_BITS  (COORD_BITS)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .sts            (sts),
    .new_anchor     (new_anchor),
    .anchor_y       (anchor_y),
    .anchor_z       (anchor_z),
    .cand_y         (cand_y),
    .cand_z         (cand_z),
    .is_edge        (is_edge),
    .front_overflow (front_overflow)
  );

endmodule

// File: src/mbes3d_checker.sv
// ----------------------------------------------------------------------------
// mbes3d_checker
// Port-level checks on the staircase block, bound to the top level.
// ----------------------------------------------------------------------------
module mbes3d_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input logic is_edge,
  input logic front_overflow
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(is_edge) && $stable(front_overflow))
    else $error("result changed while stalled");

  // an overflow only comes with an edge
  a_ovf_edge: assert property (@(posedge clk) disable iff (rst)
    out_valid && !is_edge |-> !front_overflow)
    else $error("overflow on a non-edge result");

  // nothing pending out of reset
  a_rst_clear: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("result or busy after reset");

  // busy right after a transfer in
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken twice in a row");

endmodule

bind minibox_edge_staircase_3d_top mbes3d_checker u_mbes3d_checker (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .is_edge        (is_edge),
  .front_overflow (front_overflow)
);
